>>> rtl/wmmmr_pkg.sv
// ----------------------------------------------------------------------------
// wmmmr_pkg
// Width helpers and the queue depth shared by the window statistics front end, queue and back end.
// ----------------------------------------------------------------------------
package wmmmr_pkg;

    // entries in the queue between the accumulator and the divide/root engine
    localparam int QUEUE_DEPTH = 2;

    // bits of the sample counter, wide enough to hold the window limit itself
    function automatic int count_bits(input int max_window);
        return $clog2(max_window + 1);
    endfunction

    // signed running sum: sample width plus counter width
    function automatic int sum_bits(input int sample_bits, input int cnt_bits);
        return sample_bits + cnt_bits;
    endfunction

    // unsigned running sum of squares
    function automatic int square_bits(input int sample_bits, input int cnt_bits);
        return 2 * sample_bits + cnt_bits - 2;
    endfunction

endpackage

>>> rtl/wmmmr_front.sv
// ----------------------------------------------------------------------------
// wmmmr_front
// Sample intake: registers each sample with its square, then folds it into
// the running min, max, sum, sum of squares and count. The last sample of a
// window pushes the window totals into the queue and clears the accumulators.
// ----------------------------------------------------------------------------
module wmmmr_front #(
    parameter int  SAMPLE_BITS = 16,
    parameter int  MAX_WINDOW  = 4096,
    localparam int CNT_W       = wmmmr_pkg::count_bits(MAX_WINDOW),
    localparam int SUM_W       = wmmmr_pkg::sum_bits(SAMPLE_BITS, CNT_W),
    localparam int SQ_W        = wmmmr_pkg::square_bits(SAMPLE_BITS, CNT_W)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last_sample,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic signed [SAMPLE_BITS-1:0] win_max,
    output logic signed [SAMPLE_BITS-1:0] win_min,
    output logic signed [SUM_W-1:0]       win_sum,
    output logic [SQ_W-1:0]               win_square_sum,
    output logic [CNT_W-1:0]              win_count,
    output logic                          win_dropped
);
    import wmmmr_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int SQ1W = 2 * SB - 1;

    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

    logic signed [2*SB-1:0] square_full;
    logic                   accept;
    logic                   s1_take;
    logic                   fire;
    logic                   room;

    logic                   s1_valid_reg;
    logic signed [SB-1:0]   s1_sample_reg;
    logic [SQ1W-1:0]        s1_square_reg;
    logic                   s1_last_reg;

    logic signed [SB-1:0]   min_reg, min_next;
    logic signed [SB-1:0]   max_reg, max_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   dropped_reg, dropped_next;

    // square of the incoming sample, registered with it
    assign square_full = sample * sample;

    // a held last sample waits only for room in the queue
    assign s1_take      = !s1_last_reg || push_ready;
    assign sample_ready = !s1_valid_reg || s1_take;
    assign accept       = sample_valid && sample_ready;
    assign fire         = s1_valid_reg && s1_take;

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
            s1_square_reg <= square_full[SQ1W-1:0];
            s1_last_reg   <= last_sample;
        end
    end

    // accumulate while the window has room, otherwise mark the drop
    always_comb
    begin
        room         = count_reg < CNT_W'(MAX_WINDOW);
        min_next     = min_reg;
        max_next     = max_reg;
        sum_next     = sum_reg;
        sq_next      = sq_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (room)
        begin
            if (s1_sample_reg < min_reg)
            begin
                min_next = s1_sample_reg;
            end
            if (s1_sample_reg > max_reg)
            begin
                max_next = s1_sample_reg;
            end
            sum_next   = sum_reg + {{(SUM_W-SB){s1_sample_reg[SB-1]}}, s1_sample_reg};
            sq_next    = sq_reg + {{(SQ_W-SQ1W){1'b0}}, s1_square_reg};
            count_next = count_reg + 1'b1;
        end
        else
        begin
            dropped_next = 1'b1;
        end
    end

    // window totals go to the queue together with the last sample
    assign push_valid     = fire && s1_last_reg;
    assign win_max        = max_next;
    assign win_min        = min_next;
    assign win_sum        = sum_next;
    assign win_square_sum = sq_next;
    assign win_count      = count_next;
    assign win_dropped    = dropped_next;

    // accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg     <= SMAX;
            max_reg     <= SMIN;
            sum_reg     <= '0;
            sq_reg      <= '0;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (s1_last_reg)
            begin
                min_reg     <= SMAX;
                max_reg     <= SMIN;
                sum_reg     <= '0;
                sq_reg      <= '0;
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
            else
            begin
                min_reg     <= min_next;
                max_reg     <= max_next;
                sum_reg     <= sum_next;
                sq_reg      <= sq_next;
                count_reg   <= count_next;
                dropped_reg <= dropped_next;
            end
        end
    end

endmodule

>>> rtl/wmmmr_queue.sv
// ----------------------------------------------------------------------------
// wmmmr_queue
// Small first-in first-out queue of window totals between the accumulator
// and the divide/root engine.
// ----------------------------------------------------------------------------
module wmmmr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             head_valid,
    input  logic             head_pop,
    output logic [WIDTH-1:0] head_data
);
    import wmmmr_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]  entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = fill_reg != FILL_W'(QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = head_pop && head_valid;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/wmmmr_back.sv
// ----------------------------------------------------------------------------
// wmmmr_back
// Divide and root engine: two restoring dividers share one step counter to
// form sum/count and sum_of_squares/count a bit per cycle, then a digit
// recurrence takes the integer square root two radicand bits per cycle.
// ----------------------------------------------------------------------------
module wmmmr_back #(
    parameter int  SAMPLE_BITS = 16,
    parameter int  MAX_WINDOW  = 4096,
    localparam int CNT_W       = wmmmr_pkg::count_bits(MAX_WINDOW),
    localparam int SUM_W       = wmmmr_pkg::sum_bits(SAMPLE_BITS, CNT_W),
    localparam int SQ_W        = wmmmr_pkg::square_bits(SAMPLE_BITS, CNT_W)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    output logic                          head_pop,
    input  logic signed [SAMPLE_BITS-1:0] head_max,
    input  logic signed [SAMPLE_BITS-1:0] head_min,
    input  logic signed [SUM_W-1:0]       head_sum,
    input  logic [SQ_W-1:0]               head_square_sum,
    input  logic [CNT_W-1:0]              head_count,
    input  logic                          head_dropped,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [SAMPLE_BITS-1:0] max_value,
    output logic signed [SAMPLE_BITS-1:0] min_value,
    output logic signed [SAMPLE_BITS-1:0] mean_value,
    output logic [SAMPLE_BITS-1:0]        rms_value,
    output logic [CNT_W-1:0]              sample_count,
    output logic                          window_overflow
);
    import wmmmr_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int STEP_W = $clog2(SQ_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROOT,
        ST_HOLD
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [CNT_W-1:0]    divisor_reg;
    logic [SQ_W-1:0]     dsq_reg;
    logic [SQ_W-1:0]     dsm_reg;
    logic [CNT_W-1:0]    rsq_reg;
    logic [CNT_W-1:0]    rsm_reg;
    logic                neg_reg;
    logic                empty_reg;
    logic signed [SB-1:0] max_reg;
    logic signed [SB-1:0] min_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                dropped_reg;
    logic signed [SB-1:0] mean_reg;
    logic [2*SB-1:0]     rad_reg;
    logic [SB-1:0]       root_reg;
    logic [SB+1:0]       rrem_reg;

    logic                result_valid_reg;
    logic signed [SB-1:0] max_out_reg;
    logic signed [SB-1:0] min_out_reg;
    logic signed [SB-1:0] mean_out_reg;
    logic [SB-1:0]       rms_out_reg;
    logic [CNT_W-1:0]    count_out_reg;
    logic                dropped_out_reg;

    logic [SUM_W-1:0]    sum_mag;
    logic [CNT_W:0]      rs_sq, rs_sm;
    logic                ge_sq, ge_sm;
    logic [CNT_W-1:0]    rsq_next, rsm_next;
    logic [SQ_W-1:0]     dsq_next, dsm_next;
    logic [SB-1:0]       q_mean;
    logic signed [SB-1:0] mean_next;
    logic [SB+1:0]       rr_shift;
    logic [SB+1:0]       trial;
    logic                ge_rt;
    logic [SB+1:0]       rrem_next;
    logic [SB-1:0]       root_next;
    logic                out_free;

    // magnitude of the window sum, the sign is applied after division
    assign sum_mag = head_sum[SUM_W-1] ? SUM_W'(-head_sum) : SUM_W'(head_sum);

    // one restoring step of each divider
    always_comb
    begin
        rs_sq    = {rsq_reg, dsq_reg[SQ_W-1]};
        ge_sq    = rs_sq >= {1'b0, divisor_reg};
        rsq_next = ge_sq ? CNT_W'(rs_sq - {1'b0, divisor_reg}) : rs_sq[CNT_W-1:0];
        dsq_next = {dsq_reg[SQ_W-2:0], ge_sq};

        rs_sm    = {rsm_reg, dsm_reg[SQ_W-1]};
        ge_sm    = rs_sm >= {1'b0, divisor_reg};
        rsm_next = ge_sm ? CNT_W'(rs_sm - {1'b0, divisor_reg}) : rs_sm[CNT_W-1:0];
        dsm_next = {dsm_reg[SQ_W-2:0], ge_sm};

        q_mean    = dsm_next[SB-1:0];
        mean_next = neg_reg ? SB'(-q_mean) : SB'(q_mean);
    end

    // one digit of the square root recurrence
    always_comb
    begin
        rr_shift  = {rrem_reg[SB-1:0], rad_reg[2*SB-1:2*SB-2]};
        trial     = {root_reg, 2'b01};
        ge_rt     = rr_shift >= trial;
        rrem_next = ge_rt ? rr_shift - trial : rr_shift;
        root_next = {root_reg[SB-2:0], ge_rt};
    end

    assign head_pop = (state_reg == ST_IDLE) && head_valid;
    assign out_free = !result_valid_reg || result_ready;

    // sequencer, datapath and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            divisor_reg      <= '0;
            dsq_reg          <= '0;
            dsm_reg          <= '0;
            rsq_reg          <= '0;
            rsm_reg          <= '0;
            neg_reg          <= 1'b0;
            empty_reg        <= 1'b0;
            max_reg          <= '0;
            min_reg          <= '0;
            count_reg        <= '0;
            dropped_reg      <= 1'b0;
            mean_reg         <= '0;
            rad_reg          <= '0;
            root_reg         <= '0;
            rrem_reg         <= '0;
            result_valid_reg <= 1'b0;
            max_out_reg      <= '0;
            min_out_reg      <= '0;
            mean_out_reg     <= '0;
            rms_out_reg      <= '0;
            count_out_reg    <= '0;
            dropped_out_reg  <= 1'b0;
        end
        else
        begin
            // a result leaving while a new one loads is handled in ST_HOLD
            if (result_valid_reg && result_ready && (state_reg != ST_HOLD))
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        divisor_reg <= head_count;
                        dsq_reg     <= head_square_sum;
                        dsm_reg     <= {{(SQ_W-SUM_W){1'b0}}, sum_mag};
                        rsq_reg     <= '0;
                        rsm_reg     <= '0;
                        neg_reg     <= head_sum[SUM_W-1];
                        empty_reg   <= head_count == '0;
                        max_reg     <= head_max;
                        min_reg     <= head_min;
                        count_reg   <= head_count;
                        dropped_reg <= head_dropped;
                        step_reg    <= STEP_W'(SQ_W);
                        state_reg   <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    dsq_reg  <= dsq_next;
                    dsm_reg  <= dsm_next;
                    rsq_reg  <= rsq_next;
                    rsm_reg  <= rsm_next;
                    if (step_reg == STEP_W'(1))
                    begin
                        mean_reg  <= mean_next;
                        rad_reg   <= dsq_next[2*SB-1:0];
                        root_reg  <= '0;
                        rrem_reg  <= '0;
                        step_reg  <= STEP_W'(SB);
                        state_reg <= ST_ROOT;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end

                ST_ROOT:
                begin
                    rad_reg  <= {rad_reg[2*SB-3:0], 2'b00};
                    root_reg <= root_next;
                    rrem_reg <= rrem_next;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == STEP_W'(1))
                    begin
                        state_reg <= ST_HOLD;
                    end
                end

                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        max_out_reg      <= max_reg;
                        min_out_reg      <= min_reg;
                        mean_out_reg     <= empty_reg ? '0 : mean_reg;
                        rms_out_reg      <= empty_reg ? '0 : root_reg;
                        count_out_reg    <= count_reg;
                        dropped_out_reg  <= dropped_reg;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid    = result_valid_reg;
    assign max_value       = max_out_reg;
    assign min_value       = min_out_reg;
    assign mean_value      = mean_out_reg;
    assign rms_value       = rms_out_reg;
    assign sample_count    = count_out_reg;
    assign window_overflow = dropped_out_reg;

endmodule

>>> rtl/window_min_max_mean_rms.sv
// Window totals enter the queue with the last sample; the engine pops in ST_IDLE, then
// runs ST_DIV and ST_ROOT and loads the result register in ST_HOLD. SQ_W is 2*SAMPLE_BITS
// + count bits - 2. Throughput: one sample per cycle while the two-entry queue of window
// totals has room; the engine takes one window at a time and waits on any result stall,
// so short windows stall intake. Reset (rst_n, asynchronous, active low) empties
// pipeline, queue and result register and returns accumulators to an empty window.
// ----------------------------------------------------------------------------
// window_min_max_mean_rms
// Window statistics: per window of signed samples, the max, min, truncated
// mean, integer RMS, sample count and a flag for samples dropped at the limit.
// ----------------------------------------------------------------------------
module window_min_max_mean_rms #(
    parameter int  SAMPLE_BITS = 16,
    parameter int  MAX_WINDOW  = 4096,
    localparam int CNT_W       = wmmmr_pkg::count_bits(MAX_WINDOW)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last_sample,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    output logic signed [SAMPLE_BITS-1:0] max_value,
    output logic signed [SAMPLE_BITS-1:0] min_value,
    output logic signed [SAMPLE_BITS-1:0] mean_value,
    output logic [SAMPLE_BITS-1:0]        rms_value,
    output logic [CNT_W-1:0]              sample_count,
    output logic                          window_overflow,
    output logic                          result_valid,
    input  logic                          result_ready
);
    import wmmmr_pkg::*;

    localparam int SB      = SAMPLE_BITS;
    localparam int SUM_W   = sum_bits(SB, CNT_W);
    localparam int SQ_W    = square_bits(SB, CNT_W);
    localparam int ENTRY_W = 2 * SB + SUM_W + SQ_W + CNT_W + 1;

    logic                    push_valid;
    logic                    push_ready;
    logic signed [SB-1:0]    win_max;
    logic signed [SB-1:0]    win_min;
    logic signed [SUM_W-1:0] win_sum;
    logic [SQ_W-1:0]         win_square_sum;
    logic [CNT_W-1:0]        win_count;
    logic                    win_dropped;
    logic [ENTRY_W-1:0]      push_data;
    logic [ENTRY_W-1:0]      head_data;
    logic                    head_valid;
    logic                    head_pop;
    logic signed [SB-1:0]    head_max;
    logic signed [SB-1:0]    head_min;
    logic signed [SUM_W-1:0] head_sum;
    logic [SQ_W-1:0]         head_square_sum;
    logic [CNT_W-1:0]        head_count;
    logic                    head_dropped;

    // sample intake and accumulation
    wmmmr_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample),
        .last_sample    (last_sample),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .win_max        (win_max),
        .win_min        (win_min),
        .win_sum        (win_sum),
        .win_square_sum (win_square_sum),
        .win_count      (win_count),
        .win_dropped    (win_dropped)
    );

    // window totals queue
    assign push_data = {win_max, win_min, win_sum, win_square_sum, win_count, win_dropped};

    wmmmr_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_data  (head_data)
    );

    assign {head_max, head_min, head_sum, head_square_sum, head_count, head_dropped} = head_data;

    // divide and root engine with result register
    wmmmr_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_pop        (head_pop),
        .head_max        (head_max),
        .head_min        (head_min),
        .head_sum        (head_sum),
        .head_square_sum (head_square_sum),
        .head_count      (head_count),
        .head_dropped    (head_dropped),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .max_value       (max_value),
        .min_value       (min_value),
        .mean_value      (mean_value),
        .rms_value       (rms_value),
        .sample_count    (sample_count),
        .window_overflow (window_overflow)
    );

endmodule
